// ----- rtl/imu_align_pkg.sv -----
// Shared types and constants for the accelerometer-to-gyroscope time alignment block.
// No dependencies.
`default_nettype none

package imu_align_pkg;

  localparam int unsigned TIME_W = 63;

  localparam logic KIND_ACCEL = 1'b0;
  localparam logic KIND_GYRO  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/imu_accel_to_gyro_time_align.sv -----
// Accelerometer-to-gyroscope time alignment: top level with bit-serial divider and multipliers.
// Depends on imu_align_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one timestamped three-axis sample per
//   transaction, kind_i selecting accelerometer (0) or gyroscope (1). A gyro transaction is
//   stored and produces nothing. An accel transaction produces one result on the
//   output channel (out_valid_o / out_stall_i) once a previous accel and a gyro sample exist:
//   the accel value interpolated to the stored gyro time, the stored gyro value and its host
//   time.
//   A producing accel transaction passes through a setup state, the divider (skipped when the
//   fraction saturates to 0 or 1), the multiply state and the output register. The restoring
//   divider (one quotient bit per cycle) and the shift-add multipliers (one fraction bit per
//   cycle, three axes in parallel) do this work; one item is in work at a time.
//   Non-producing transactions do not stall the input; after a producing one the next
//   transaction is accepted only once the result has entered the output register.
//   The output register holds a result while out_stall_i is high; in_stall_o stays high until
//   a finished result enters that register, so a stalled result also holds the input.
//   Reset clears the seen flags and the output valid; the block is ready right after reset.
`default_nettype none

module imu_accel_to_gyro_time_align #(
  parameter int unsigned SAMPLE_WIDTH  = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              kind_i,
  input  wire logic [imu_align_pkg::TIME_W-1:0]  sample_time_i,
  input  wire logic [imu_align_pkg::TIME_W-1:0]  host_time_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    axis_x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    axis_y_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    axis_z_i,

  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]         accel_x_o,
  output logic signed [SAMPLE_WIDTH-1:0]         accel_y_o,
  output logic signed [SAMPLE_WIDTH-1:0]         accel_z_o,
  output logic signed [SAMPLE_WIDTH-1:0]         gyro_x_o,
  output logic signed [SAMPLE_WIDTH-1:0]         gyro_y_o,
  output logic signed [SAMPLE_WIDTH-1:0]         gyro_z_o,
  output logic [imu_align_pkg::TIME_W-1:0]       gyro_host_time_o
);

  localparam int unsigned TW    = imu_align_pkg::TIME_W;
  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned DW    = TW + 1;
  localparam int unsigned AW    = SW + FB + 1;
  localparam int unsigned CNT_W = $clog2(FB + 2);

  localparam logic [SW-1:0]  BIAS     = SW'(1) << (SW - 1);
  localparam logic [FB:0]    ONE_FX   = (FB + 1)'(1) << FB;
  localparam logic [AW-1:0]  HALF     = AW'(1) << (FB - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FB - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FB);

  imu_align_pkg::state_e state_q, state_d;

  logic              accel_seen_q, gyro_seen_q;
  logic [SW-1:0]     prev_accel_q [3];
  logic [SW-1:0]     held_gyro_q  [3];
  logic [TW-1:0]     prev_time_q, gyro_time_q, gyro_host_q;

  logic [DW-1:0]     span_q, num_q, rem_q;
  logic [FB:0]       alpha_q, alpha_d, beta_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [AW-1:0]     bp_sh_q [3];
  logic [AW-1:0]     bc_sh_q [3];
  logic [AW-1:0]     acc_q   [3];

  logic              out_valid_q;
  logic [SW-1:0]     out_accel_q [3];
  logic [SW-1:0]     out_gyro_q  [3];
  logic [TW-1:0]     out_host_q;

  logic [SW-1:0]     axis_in [3];
  logic              in_acc, out_free, alpha_zero, alpha_one, rem_ge, mul_enter;
  logic [DW-1:0]     rem_shift, rem_d;

  assign axis_in[0] = axis_x_i;
  assign axis_in[1] = axis_y_i;
  assign axis_in[2] = axis_z_i;

  assign in_stall_o = (state_q != imu_align_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign alpha_zero = span_q[DW-1] || (span_q == '0) || num_q[DW-1] || (num_q == '0);
  assign alpha_one  = (num_q >= span_q);

  assign rem_shift  = {rem_q[DW-2:0], 1'b0};
  assign rem_ge     = (rem_shift >= span_q);
  assign rem_d      = rem_ge ? (rem_shift - span_q) : rem_shift;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imu_align_pkg::ST_IDLE: begin
        if (in_acc && (kind_i == imu_align_pkg::KIND_ACCEL) && accel_seen_q && gyro_seen_q) begin
          state_d = imu_align_pkg::ST_PREP;
        end
      end
      imu_align_pkg::ST_PREP: begin
        if (alpha_zero || alpha_one) begin
          state_d = imu_align_pkg::ST_MUL;
        end else begin
          state_d = imu_align_pkg::ST_DIV;
        end
      end
      imu_align_pkg::ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = imu_align_pkg::ST_MUL;
        end
      end
      imu_align_pkg::ST_MUL: begin
        if (cnt_q == MUL_LAST) begin
          state_d = imu_align_pkg::ST_DONE;
        end
      end
      imu_align_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = imu_align_pkg::ST_IDLE;
        end
      end
      default: state_d = imu_align_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alpha_d = alpha_q;
    priority case (state_q)
      imu_align_pkg::ST_PREP: begin
        if (alpha_zero) begin
          alpha_d = '0;
        end else if (alpha_one) begin
          alpha_d = ONE_FX;
        end else begin
          alpha_d = '0;
        end
      end
      imu_align_pkg::ST_DIV: alpha_d = {alpha_q[FB-1:0], rem_ge};
      imu_align_pkg::ST_MUL: alpha_d = alpha_q >> 1;
      default:               alpha_d = alpha_q;
    endcase
  end

  assign mul_enter = (state_d == imu_align_pkg::ST_MUL) && (state_q != imu_align_pkg::ST_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= imu_align_pkg::ST_IDLE;
      accel_seen_q <= 1'b0;
      gyro_seen_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (kind_i == imu_align_pkg::KIND_GYRO) begin
          gyro_seen_q <= 1'b1;
        end else begin
          accel_seen_q <= 1'b1;
        end
      end
      if ((state_q == imu_align_pkg::ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= alpha_d;
    if (mul_enter) begin
      beta_q <= ONE_FX - alpha_d;
    end else if (state_q == imu_align_pkg::ST_MUL) begin
      beta_q <= beta_q >> 1;
    end

    if (state_q == imu_align_pkg::ST_PREP) begin
      rem_q <= num_q;
      cnt_q <= '0;
    end else if (state_q == imu_align_pkg::ST_DIV) begin
      rem_q <= rem_d;
      cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + 1'b1;
    end else if (state_q == imu_align_pkg::ST_MUL) begin
      cnt_q <= cnt_q + 1'b1;
    end

    if (in_acc) begin
      if (kind_i == imu_align_pkg::KIND_GYRO) begin
        for (int k = 0; k < 3; k++) begin
          held_gyro_q[k] <= axis_in[k];
        end
        gyro_time_q <= sample_time_i;
        gyro_host_q <= host_time_i;
      end else begin
        for (int k = 0; k < 3; k++) begin
          bp_sh_q[k]      <= AW'(prev_accel_q[k] ^ BIAS);
          bc_sh_q[k]      <= AW'(axis_in[k] ^ BIAS);
          acc_q[k]        <= HALF;
          prev_accel_q[k] <= axis_in[k];
        end
        span_q      <= {1'b0, sample_time_i} - {1'b0, prev_time_q};
        num_q       <= {1'b0, gyro_time_q} - {1'b0, prev_time_q};
        prev_time_q <= sample_time_i;
      end
    end

    if (state_q == imu_align_pkg::ST_MUL) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k]   <= acc_q[k] + (alpha_q[0] ? bc_sh_q[k] : '0)
                               + (beta_q[0]  ? bp_sh_q[k] : '0);
        bp_sh_q[k] <= bp_sh_q[k] << 1;
        bc_sh_q[k] <= bc_sh_q[k] << 1;
      end
    end

    if ((state_q == imu_align_pkg::ST_DONE) && out_free) begin
      for (int k = 0; k < 3; k++) begin
        out_accel_q[k] <= acc_q[k][FB +: SW] ^ BIAS;
        out_gyro_q[k]  <= held_gyro_q[k];
      end
      out_host_q <= gyro_host_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accel_x_o        = out_accel_q[0];
  assign accel_y_o        = out_accel_q[1];
  assign accel_z_o        = out_accel_q[2];
  assign gyro_x_o         = out_gyro_q[0];
  assign gyro_y_o         = out_gyro_q[1];
  assign gyro_z_o         = out_gyro_q[2];
  assign gyro_host_time_o = out_host_q;

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == imu_align_pkg::ST_DONE)
    else $error("result valid without a finished computation");

  a_weights_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imu_align_pkg::ST_MUL && cnt_q == '0)
      |-> ((FB + 2)'(alpha_q) + (FB + 2)'(beta_q)) == (FB + 2)'(ONE_FX))
    else $error("interpolation weights do not sum to one");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imu_align_pkg::ST_DIV) |-> rem_q < span_q)
    else $error("divider remainder out of range");

  a_gyro_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == imu_align_pkg::KIND_GYRO) |=> state_q == imu_align_pkg::ST_IDLE)
    else $error("gyro transaction started a computation");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- bench/imu_accel_to_gyro_time_align_tb.sv -----
// Self-checking bench for imu_accel_to_gyro_time_align: a directed table, then random
// accel/gyro sample streams with random idling, checked against an in-bench interpolator.
// Depends on imu_align_pkg and the block's top level.
`default_nettype none

module imu_accel_to_gyro_time_align_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW = 16;
  localparam int unsigned FB = 16;
  localparam int unsigned TW = imu_align_pkg::TIME_W;
  localparam logic [63:0] ONE_FX = 64'd1 << FB;
  localparam logic [TW-1:0] T_MAX = {TW{1'b1}};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * FB + 8;
  localparam int N_RANDOM = 1880;
  localparam int QUIET_TAIL = 200;
  localparam int PAUSE_AT = 900;

  typedef struct {
    logic                 kind;
    logic [TW-1:0]        t;
    logic [TW-1:0]        host;
    logic signed [SW-1:0] axis [3];
  } sample_t;

  typedef struct {
    logic signed [SW-1:0] accel [3];
    logic signed [SW-1:0] gyro [3];
    logic [TW-1:0]        host;
  } aligned_t;

  typedef struct {
    sample_t  s;
    bit       typed;
    aligned_t want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = imu_align_pkg::KIND_ACCEL;
  logic [TW-1:0]        sample_time_i = '0;
  logic [TW-1:0]        host_time_i = '0;
  logic signed [SW-1:0] axis_x_i = '0;
  logic signed [SW-1:0] axis_y_i = '0;
  logic signed [SW-1:0] axis_z_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [SW-1:0] accel_x_o;
  logic signed [SW-1:0] accel_y_o;
  logic signed [SW-1:0] accel_z_o;
  logic signed [SW-1:0] gyro_x_o;
  logic signed [SW-1:0] gyro_y_o;
  logic signed [SW-1:0] gyro_z_o;
  logic [TW-1:0]        gyro_host_time_o;

  imu_accel_to_gyro_time_align #(
    .SAMPLE_WIDTH (SW),
    .FRACTION_BITS(FB)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .sample_time_i   (sample_time_i),
    .host_time_i     (host_time_i),
    .axis_x_i        (axis_x_i),
    .axis_y_i        (axis_y_i),
    .axis_z_i        (axis_z_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accel_x_o       (accel_x_o),
    .accel_y_o       (accel_y_o),
    .accel_z_o       (accel_z_o),
    .gyro_x_o        (gyro_x_o),
    .gyro_y_o        (gyro_y_o),
    .gyro_z_o        (gyro_z_o),
    .gyro_host_time_o(gyro_host_time_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Interpolator state.
  logic signed [SW-1:0] acc_prev [3];
  logic [TW-1:0]        acc_prev_t;
  logic signed [SW-1:0] gyr_held [3];
  logic [TW-1:0]        gyr_t;
  logic [TW-1:0]        gyr_host;
  bit                   acc_seen;
  bit                   gyr_seen;

  aligned_t aligned_q [$];
  row_t     directed_rows [$];
  aligned_t pend_want;
  bit       pend_typed;
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  int       errors = 0;
  int       quiet_cycles = 0;
  logic [TW-1:0] base_t = '0;

  function automatic logic [FB:0] frac_at_gyro(input logic [TW-1:0] t_prev, t_gyro, t_new);
    logic [63:0] span;
    logic [63:0] rem;
    logic [FB:0] q;
    q = '0;
    if (t_new <= t_prev || t_gyro <= t_prev) return '0;
    span = {1'b0, t_new} - {1'b0, t_prev};
    rem  = {1'b0, t_gyro} - {1'b0, t_prev};
    if (rem >= span) return ONE_FX[FB:0];
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= span) begin
        rem = rem - span;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [SW-1:0] mix(input logic signed [SW-1:0] a, b,
                                               input logic [FB:0] w);
    logic [63:0] ba;
    logic [63:0] bb;
    logic [63:0] acc;
    ba  = 64'({~a[SW-1], a[SW-2:0]});
    bb  = 64'({~b[SW-1], b[SW-2:0]});
    acc = ba * (ONE_FX - 64'(w)) + bb * 64'(w) + (ONE_FX >> 1);
    return {~acc[FB+SW-1], acc[FB+SW-2:FB]};
  endfunction

  function automatic bit align_predict(input sample_t s, output aligned_t r);
    logic [FB:0] w;
    bit made;
    made = 1'b0;
    r = '{default: '0};
    if (s.kind == imu_align_pkg::KIND_GYRO) begin
      for (int i = 0; i < 3; i++) gyr_held[i] = s.axis[i];
      gyr_t = s.t;
      gyr_host = s.host;
      gyr_seen = 1'b1;
      return 1'b0;
    end
    if (acc_seen && gyr_seen) begin
      w = frac_at_gyro(acc_prev_t, gyr_t, s.t);
      for (int i = 0; i < 3; i++) begin
        r.accel[i] = mix(acc_prev[i], s.axis[i], w);
        r.gyro[i]  = gyr_held[i];
      end
      r.host = gyr_host;
      made = 1'b1;
    end
    for (int i = 0; i < 3; i++) acc_prev[i] = s.axis[i];
    acc_prev_t = s.t;
    acc_seen = 1'b1;
    return made;
  endfunction

  task automatic report_mismatch(input string what, input logic [TW-1:0] got, want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [TW-1:0] got, want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic add_want(input int ax, ay, az, gx, gy, gz, input logic [TW-1:0] host);
    pend_want.accel[0] = SW'(ax);
    pend_want.accel[1] = SW'(ay);
    pend_want.accel[2] = SW'(az);
    pend_want.gyro[0]  = SW'(gx);
    pend_want.gyro[1]  = SW'(gy);
    pend_want.gyro[2]  = SW'(gz);
    pend_want.host     = host;
    pend_typed = 1'b1;
  endtask

  task automatic add_row(input logic kind, input logic [TW-1:0] t, host, input int x, y, z);
    row_t row;
    row.s.kind = kind;
    row.s.t = t;
    row.s.host = host;
    row.s.axis[0] = SW'(x);
    row.s.axis[1] = SW'(y);
    row.s.axis[2] = SW'(z);
    row.typed = pend_typed;
    row.want = pend_want;
    pend_typed = 1'b0;
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [SW-1:0] rand_axis();
    logic signed [SW-1:0] picks [4];
    picks = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    if ($urandom_range(0, 9) == 0) return picks[$urandom_range(0, 3)];
    return SW'($urandom);
  endfunction

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TW-1:0];
  endfunction

  // Mostly rising timestamps with interleaved gyro samples; some equal, backwards, or wild.
  task automatic next_random(output sample_t s);
    int mode;
    mode = $urandom_range(0, 99);
    s.kind = ($urandom_range(0, 99) < 55) ? imu_align_pkg::KIND_ACCEL : imu_align_pkg::KIND_GYRO;
    if (mode < 70) begin
      s.t = base_t + TW'($urandom_range(1, 5000));
      base_t = s.t;
    end else if (mode < 80) begin
      s.t = base_t;
    end else if (mode < 88) begin
      s.t = base_t - TW'($urandom_range(1, 5000));
    end else begin
      s.t = rand_time();
      base_t = s.t;
    end
    s.host = rand_time();
    for (int i = 0; i < 3; i++) s.axis[i] = rand_axis();
  endtask

  task automatic send_sample(input sample_t s, input bit typed, input aligned_t want);
    aligned_t r;
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= s.kind;
    sample_time_i <= s.t;
    host_time_i   <= s.host;
    axis_x_i      <= s.axis[0];
    axis_y_i      <= s.axis[1];
    axis_z_i      <= s.axis[2];
    do @(posedge clk_i); while (in_stall_o);
    if (align_predict(s, r) && !typed) aligned_q.push_back(r);
    if (typed) aligned_q.push_back(want);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni || !idle_on) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    aligned_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (aligned_q.size() == 0) begin
          report_mismatch("unexpected result, host", gyro_host_time_o, '0);
        end else begin
          exp_r = aligned_q.pop_front();
          check_field("accel_x", TW'(accel_x_o), TW'(exp_r.accel[0]));
          check_field("accel_y", TW'(accel_y_o), TW'(exp_r.accel[1]));
          check_field("accel_z", TW'(accel_z_o), TW'(exp_r.accel[2]));
          check_field("gyro_x", TW'(gyro_x_o), TW'(exp_r.gyro[0]));
          check_field("gyro_y", TW'(gyro_y_o), TW'(exp_r.gyro[1]));
          check_field("gyro_z", TW'(gyro_z_o), TW'(exp_r.gyro[2]));
          check_field("gyro_host_time", gyro_host_time_o, exp_r.host);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("imu_accel_to_gyro_time_align_tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    sample_t  s;
    aligned_t none;
    none = '{default: '0};
    acc_prev = '{default: '0};
    gyr_held = '{default: '0};
    acc_prev_t = '0;
    gyr_t = '0;
    gyr_host = '0;
    acc_seen = 1'b0;
    gyr_seen = 1'b0;
    pend_typed = 1'b0;
    pend_want = none;

    // First accel, then accel with no gyro yet: nothing comes out.
    add_row(imu_align_pkg::KIND_ACCEL, 100, 0, -32768, 32767, 0);
    add_row(imu_align_pkg::KIND_ACCEL, 200, T_MAX, 32767, -32768, -1);
    add_row(imu_align_pkg::KIND_GYRO, 250, T_MAX, 32767, -32768, -1);
    add_row(imu_align_pkg::KIND_ACCEL, 300, 0, 0, 1234, -32768);
    // Zero span: previous accel.
    add_want(0, 1234, -32768, 32767, -32768, -1, T_MAX);
    add_row(imu_align_pkg::KIND_ACCEL, 300, 0, 5, 6, 7);
    add_row(imu_align_pkg::KIND_GYRO, 10000, 1, -32768, 32767, 0);
    // Gyro past the new accel: fraction saturates, new accel.
    add_want(-32768, 32767, 1, -32768, 32767, 0, 1);
    add_row(imu_align_pkg::KIND_ACCEL, 400, 0, -32768, 32767, 1);
    add_row(imu_align_pkg::KIND_GYRO, 400, 2, 1, 2, 3);
    // Gyro at the previous accel time: previous accel.
    add_want(-32768, 32767, 1, 1, 2, 3, 2);
    add_row(imu_align_pkg::KIND_ACCEL, 500, T_MAX, 100, 200, 300);
    // Time going backwards: previous accel.
    add_want(100, 200, 300, 1, 2, 3, 2);
    add_row(imu_align_pkg::KIND_ACCEL, 450, 0, 7, 8, 9);
    add_row(imu_align_pkg::KIND_GYRO, T_MAX, T_MAX, -1, -1, -1);
    add_want(7, 8, 9, -1, -1, -1, T_MAX);
    add_row(imu_align_pkg::KIND_ACCEL, 0, 0, 11, -12, 13);
    add_row(imu_align_pkg::KIND_GYRO, 63'h4000_0000_0000_0000, 0, 32767, 32767, 32767);
    add_row(imu_align_pkg::KIND_ACCEL, T_MAX, T_MAX, 32767, -32768, 32767);
    add_row(imu_align_pkg::KIND_GYRO, 5, 63'h5555_5555_5555_5555, -32768, -32768, -32768);
    add_want(32767, -32768, 32767, -32768, -32768, -32768, 63'h5555_5555_5555_5555);
    add_row(imu_align_pkg::KIND_ACCEL, 0, 0, 0, 0, 0);
    add_row(imu_align_pkg::KIND_ACCEL, T_MAX, 0, 32767, 32767, 32767);
    add_row(imu_align_pkg::KIND_GYRO, 63'h2aaa_aaaa_aaaa_aaaa, 63'h2aaa_aaaa_aaaa_aaaa,
            -21846, 21845, -2);
    add_row(imu_align_pkg::KIND_ACCEL, 63'h3000_0000_0000_0000, 0, -32768, -32768, 0);
    add_row(imu_align_pkg::KIND_ACCEL, 63'h3000_0000_0000_0100, 0, 32767, 1, -1);
    add_row(imu_align_pkg::KIND_GYRO, 63'h3000_0000_0000_0180, 7, -7, 7, -7);
    add_row(imu_align_pkg::KIND_ACCEL, 63'h3000_0000_0000_0200, 0, -32768, 32767, 12345);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) send_sample(directed_rows[k].s, directed_rows[k].typed,
                                           directed_rows[k].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
      if (i == PAUSE_AT) begin
        // Hold off until every pending result is out.
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (aligned_q.size() != 0) @(posedge clk_i);
      end
      next_random(s);
      send_sample(s, 1'b0, none);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (aligned_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("imu_accel_to_gyro_time_align_tb passed");
    end else begin
      $display("imu_accel_to_gyro_time_align_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
